### rtl/igbp_pkg.sv
// Shared types and constants of the implicit-grid broad phase.
`default_nettype none

package igbp_pkg;

    // Fixed field widths of the request and result ports and the in-use registers.
    localparam int IDX_W   = 5;
    localparam int BOUND_W = 6;
    localparam int CFG_W   = 7;
    localparam int FUNC_W  = 2;
    // Width that holds an effective grid size of up to 256 entries.
    localparam int SZ_W    = 9;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register select, taken from paddr[2].
    localparam logic REG_COLS_IN_USE = 1'b0;
    localparam logic REG_ROWS_IN_USE = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR    = 2'd0,
        FUNC_INSERT   = 2'd1,
        FUNC_QUERY    = 2'd2,
        FUNC_RESERVED = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // Commands from the sequencer to one axis walker.
    typedef struct packed {
        logic start;
        logic insert;
        logic clear;
    } axis_ctl_t;

endpackage

`default_nettype wire

### rtl/igbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module igbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/igbp_axis.sv
// One grid axis: mask memory, per-entry valid bits and the read-modify-write walker.
`default_nettype none

module igbp_axis #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire igbp_pkg::axis_ctl_t  ctl,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] first,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] last,
    input  wire logic [WIDTH-1:0]     obj_bit,
    output logic      [WIDTH-1:0]     acc,
    output logic                      busy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0] vld_reg;
    logic             pend_reg;
    logic             rd_pend_reg;
    logic [AW-1:0]    ptr_reg;
    logic [AW-1:0]    end_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic             rd_ev_reg;
    logic             ins_reg;
    logic [WIDTH-1:0] bit_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] rdata;
    logic [WIDTH-1:0] old_mask;
    logic             wr_en;

    // An entry never written since the last clear reads as zero.
    assign old_mask = rd_ev_reg ? rdata : '0;
    assign wr_en    = rd_pend_reg & ins_reg;
    assign acc      = acc_reg;
    assign busy     = pend_reg | rd_pend_reg;

    igbp_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (rd_addr_reg),
        .wdata (old_mask | bit_reg),
        .re    (pend_reg),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            pend_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[rd_addr_reg] <= 1'b1;
            end

            if (ctl.start)
            begin
                pend_reg    <= (first <= last);
                rd_pend_reg <= 1'b0;
            end
            else
            begin
                rd_pend_reg <= pend_reg;
                if (pend_reg && (ptr_reg == end_reg))
                begin
                    pend_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            ptr_reg <= first;
            end_reg <= last;
            ins_reg <= ctl.insert;
            bit_reg <= obj_bit;
            acc_reg <= '0;
        end
        else
        begin
            if (pend_reg)
            begin
                rd_addr_reg <= ptr_reg;
                rd_ev_reg   <= vld_reg[ptr_reg];
                if (ptr_reg != end_reg)
                begin
                    ptr_reg <= ptr_reg + AW'(1);
                end
            end
            if (rd_pend_reg && !ins_reg)
            begin
                acc_reg <= acc_reg | old_mask;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/implicit_grid_broad_phase.sv
// Top level of the implicit-grid broad phase: request port, sequencer and result port.
`default_nettype none

// The block keeps one object mask per grid row and one per grid column, each in
// its own RAM, and answers region queries by ORing masks over a row range and a
// column range and ANDing the two, less the requester's own slot under skip_self.
// Requests: a request is taken at a rising edge where start is high and busy is
// low. A clear, and an insert of a slot beyond the object count, take effect at
// that edge and leave busy low. An insert or a query walks its row and column
// ranges at the same time, one entry of each per cycle, through a read-modify-write
// pipe on each RAM.
// Results: a query result is on hit_index, hit_valid and last for one cycle under
// strobe, lowest slot first, one per cycle, and busy drops as the final one is
// registered. An empty query gives a single result with hit_valid low and last
// high. The receiver cannot stall.
// Configuration: cols_in_use at byte address 0 and rows_in_use at byte address 4
// of the APB port, to be written only while the block is idle; the block does not enforce this.
// Reset: both in-use registers return to 64 and every grid entry reads as empty;
// a clear empties the grid by dropping the valid bit of every RAM entry.
module implicit_grid_broad_phase #(
    parameter int GRID_COLS   = 64,
    parameter int GRID_ROWS   = 64,
    parameter int NUM_OBJECTS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Request port.
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [igbp_pkg::FUNC_W-1:0]       func,
    input  wire logic [igbp_pkg::IDX_W-1:0]        object_index,
    input  wire logic [igbp_pkg::BOUND_W-1:0]      col_first,
    input  wire logic [igbp_pkg::BOUND_W-1:0]      col_last,
    input  wire logic [igbp_pkg::BOUND_W-1:0]      row_first,
    input  wire logic [igbp_pkg::BOUND_W-1:0]      row_last,
    input  wire logic                              skip_self,
    // Result port.
    output logic                                   strobe,
    output logic      [igbp_pkg::IDX_W-1:0]        hit_index,
    output logic                                   hit_valid,
    output logic                                   last,
    // Configuration port.
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [igbp_pkg::APB_AW-1:0]       paddr,
    input  wire logic [igbp_pkg::APB_DW-1:0]       pwdata,
    output logic      [igbp_pkg::APB_DW-1:0]       prdata,
    output logic                                   pready
);

    // Object masks only hold the slots that exist, at most 32.
    localparam int MASK_W = (NUM_OBJECTS >= 32) ? 32 : NUM_OBJECTS;
    localparam int CAW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int RAW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam logic [igbp_pkg::SZ_W-1:0] COLS_SZ = igbp_pkg::SZ_W'(GRID_COLS);
    localparam logic [igbp_pkg::SZ_W-1:0] ROWS_SZ = igbp_pkg::SZ_W'(GRID_ROWS);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [igbp_pkg::CFG_W-1:0] cols_in_use_reg;
    logic [igbp_pkg::CFG_W-1:0] rows_in_use_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_in_use_reg <= igbp_pkg::CFG_W'(64);
            rows_in_use_reg <= igbp_pkg::CFG_W'(64);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == igbp_pkg::REG_ROWS_IN_USE)
            begin
                rows_in_use_reg <= pwdata[igbp_pkg::CFG_W-1:0];
            end
            else
            begin
                cols_in_use_reg <= pwdata[igbp_pkg::CFG_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == igbp_pkg::REG_COLS_IN_USE)
        begin
            prdata = igbp_pkg::APB_DW'(cols_in_use_reg);
        end
        else
        begin
            prdata = igbp_pkg::APB_DW'(rows_in_use_reg);
        end
    end

    // ------------------------------------------------------------------
    // Bound clamping. A zero in-use count acts as one, and a count above the
    // grid acts as the grid size. Each bound is then limited to the last
    // row or column in use.
    // ------------------------------------------------------------------
    logic [igbp_pkg::SZ_W-1:0] cols_eff;
    logic [igbp_pkg::SZ_W-1:0] rows_eff;
    logic [igbp_pkg::SZ_W-1:0] col_lim;
    logic [igbp_pkg::SZ_W-1:0] row_lim;
    logic [igbp_pkg::SZ_W-1:0] c0_full;
    logic [igbp_pkg::SZ_W-1:0] c1_full;
    logic [igbp_pkg::SZ_W-1:0] r0_full;
    logic [igbp_pkg::SZ_W-1:0] r1_full;

    always_comb
    begin
        if (cols_in_use_reg == '0)
        begin
            cols_eff = igbp_pkg::SZ_W'(1);
        end
        else if (igbp_pkg::SZ_W'(cols_in_use_reg) > COLS_SZ)
        begin
            cols_eff = COLS_SZ;
        end
        else
        begin
            cols_eff = igbp_pkg::SZ_W'(cols_in_use_reg);
        end

        if (rows_in_use_reg == '0)
        begin
            rows_eff = igbp_pkg::SZ_W'(1);
        end
        else if (igbp_pkg::SZ_W'(rows_in_use_reg) > ROWS_SZ)
        begin
            rows_eff = ROWS_SZ;
        end
        else
        begin
            rows_eff = igbp_pkg::SZ_W'(rows_in_use_reg);
        end

        col_lim = cols_eff - igbp_pkg::SZ_W'(1);
        row_lim = rows_eff - igbp_pkg::SZ_W'(1);

        c0_full = (igbp_pkg::SZ_W'(col_first) > col_lim) ? col_lim : igbp_pkg::SZ_W'(col_first);
        c1_full = (igbp_pkg::SZ_W'(col_last)  > col_lim) ? col_lim : igbp_pkg::SZ_W'(col_last);
        r0_full = (igbp_pkg::SZ_W'(row_first) > row_lim) ? row_lim : igbp_pkg::SZ_W'(row_first);
        r1_full = (igbp_pkg::SZ_W'(row_last)  > row_lim) ? row_lim : igbp_pkg::SZ_W'(row_last);
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    igbp_pkg::state_t    state_reg;
    igbp_pkg::state_t    state_next;
    igbp_pkg::axis_ctl_t axis_ctl;

    logic              accept;
    logic              start_walk;
    logic [MASK_W-1:0] obj_bit;
    logic [MASK_W-1:0] row_acc;
    logic [MASK_W-1:0] col_acc;
    logic              row_busy;
    logic              col_busy;

    logic              is_query_reg;
    logic              skip_reg;
    logic [MASK_W-1:0] self_bit_reg;
    logic [MASK_W-1:0] hits_reg;
    logic [MASK_W-1:0] hits_next;
    logic [MASK_W-1:0] hits_now;
    logic [MASK_W-1:0] low_bit;
    logic [MASK_W-1:0] remain;
    logic [igbp_pkg::IDX_W-1:0] low_idx;

    logic                       strobe_reg;
    logic                       strobe_next;
    logic [igbp_pkg::IDX_W-1:0] hit_index_reg;
    logic [igbp_pkg::IDX_W-1:0] hit_index_next;
    logic                       hit_valid_reg;
    logic                       hit_valid_next;
    logic                       last_reg;
    logic                       last_next;

    assign busy   = (state_reg != igbp_pkg::ST_IDLE);
    assign accept = start & ~busy;

    // A slot beyond the object count shifts out and leaves an empty bit.
    assign obj_bit = MASK_W'(1) << object_index;

    always_comb
    begin
        start_walk = 1'b0;
        axis_ctl   = '0;
        if (accept)
        begin
            case (igbp_pkg::func_t'(func))
                igbp_pkg::FUNC_CLEAR:
                begin
                    axis_ctl.clear = 1'b1;
                end
                igbp_pkg::FUNC_INSERT:
                begin
                    start_walk      = (obj_bit != '0);
                    axis_ctl.insert = 1'b1;
                end
                igbp_pkg::FUNC_QUERY:
                begin
                    start_walk = 1'b1;
                end
                default:
                begin
                    start_walk = 1'b0;
                end
            endcase
        end
        axis_ctl.start = start_walk;
    end

    igbp_axis #(
        .DEPTH (GRID_ROWS),
        .WIDTH (MASK_W)
    ) u_rows (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (axis_ctl),
        .first   (RAW'(r0_full)),
        .last    (RAW'(r1_full)),
        .obj_bit (obj_bit),
        .acc     (row_acc),
        .busy    (row_busy)
    );

    igbp_axis #(
        .DEPTH (GRID_COLS),
        .WIDTH (MASK_W)
    ) u_cols (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (axis_ctl),
        .first   (CAW'(c0_full)),
        .last    (CAW'(c1_full)),
        .obj_bit (obj_bit),
        .acc     (col_acc),
        .busy    (col_busy)
    );

    // Candidate set once both walks have finished.
    assign hits_now = row_acc & col_acc & ~(skip_reg ? self_bit_reg : '0);

    // Lowest set bit of the pending hits and its slot number.
    assign low_bit = hits_reg & (~hits_reg + MASK_W'(1));
    assign remain  = hits_reg & ~low_bit;

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | igbp_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        hits_next      = hits_reg;
        strobe_next    = 1'b0;
        hit_index_next = hit_index_reg;
        hit_valid_next = hit_valid_reg;
        last_next      = last_reg;
        case (state_reg)
            igbp_pkg::ST_IDLE:
            begin
                if (start_walk)
                begin
                    state_next = igbp_pkg::ST_WALK;
                end
            end
            igbp_pkg::ST_WALK:
            begin
                if (!row_busy && !col_busy)
                begin
                    if (!is_query_reg)
                    begin
                        state_next = igbp_pkg::ST_IDLE;
                    end
                    else if (hits_now == '0)
                    begin
                        // Empty query: a single result that names nothing.
                        state_next     = igbp_pkg::ST_IDLE;
                        strobe_next    = 1'b1;
                        hit_index_next = '0;
                        hit_valid_next = 1'b0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        state_next = igbp_pkg::ST_EMIT;
                        hits_next  = hits_now;
                    end
                end
            end
            igbp_pkg::ST_EMIT:
            begin
                strobe_next    = 1'b1;
                hit_index_next = low_idx;
                hit_valid_next = 1'b1;
                last_next      = (remain == '0);
                hits_next      = remain;
                if (remain == '0)
                begin
                    state_next = igbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = igbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= igbp_pkg::ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_query_reg <= (func == igbp_pkg::FUNC_QUERY);
            skip_reg     <= skip_self;
            self_bit_reg <= obj_bit;
        end
        hits_reg      <= hits_next;
        hit_index_reg <= hit_index_next;
        hit_valid_reg <= hit_valid_next;
        last_reg      <= last_next;
    end

    assign strobe    = strobe_reg;
    assign hit_index = hit_index_reg;
    assign hit_valid = hit_valid_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The final result of a query is never followed at once by another one.
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result followed the final result of a query");

    // A result that names no object only closes an empty query.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !hit_valid |-> last)
        else $error("empty-query result not marked last");

    // Results only come out of a request still being worked on.
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !strobe)
        else $error("result produced while idle");

    // Every emit cycle delivers a found object.
    a_emit_gives_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == igbp_pkg::ST_EMIT |=> strobe && hit_valid)
        else $error("emit cycle gave no hit");

endmodule

`default_nettype wire
